// ----- hdl/lcs_pkg.sv -----
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared constants for the longest common subsequence length engine.
// ----------------------------------------------------------------------------
package lcs_pkg;

   // default string capacity, range 1 to 4096
   localparam int LCS_MAX_LEN = 256;

   localparam int CHAR_W = 8;
   localparam int LEN_W  = 9;

   // stream widths, padded to whole bytes
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

   // largest length the result field can carry
   localparam logic [LEN_W-1:0] LEN_SAT = 9'h1FF;

endpackage

// ----- hdl/lcs_ram.sv -----
// ----------------------------------------------------------------------------
// lcs_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module lcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      // read data holds while re is low
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- hdl/lcs_length.sv -----
// ----------------------------------------------------------------------------
// lcs_length
// Longest common subsequence length of two equal-length byte strings.
// ----------------------------------------------------------------------------
//  channel | port group | beat contents
//  --------+------------+-----------------------------------------------------
//  input   | req_*      | one character pair, tlast on the final pair
//  result  | rsp_*      | subsequence length, tuser set if pairs were dropped
//
//  pairs load at one per cycle into the two character RAMs while req_tready
//  is high. after the final pair the score row RAM is swept one cell per
//  cycle, each row passing through the ROW, SWEEP and ROW_END states, then
//  the result is loaded into the output register from the DONE state; the
//  read-modify-write loop on the score RAM sets the sweep pace.
//  req_tready is low during the sweep; a finished result waits in the output
//  register while the next strings load. reset needs no clearing pass.
module lcs_length
   import lcs_pkg::*;
#(
   parameter int MAX_LEN = LCS_MAX_LEN
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // first_char[7:0], second_char[15:8]
   input  logic                  req_tlast,   // last_pair
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // match_length[8:0], zero fill
   output logic                  rsp_tuser    // overflow
);

   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int CW = $clog2(MAX_LEN + 1);
   localparam int SW = CW;

   localparam logic [2:0] ST_LOAD    = 3'd0;
   localparam logic [2:0] ST_ROW     = 3'd1;
   localparam logic [2:0] ST_SWEEP   = 3'd2;
   localparam logic [2:0] ST_ROW_END = 3'd3;
   localparam logic [2:0] ST_DONE    = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic [AW-1:0]    row_ff, row_in;
   logic [AW-1:0]    col_ff, col_in;
   logic             p_valid_ff, p_valid_in;
   logic [AW-1:0]    p_col_ff, p_col_in;
   logic             p_first_col_ff, p_first_col_in;
   logic [SW-1:0]    left_ff, left_in;
   logic [SW-1:0]    diag_ff, diag_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [LEN_W-1:0] rsp_len_ff, rsp_len_in;
   logic             rsp_ovf_ff, rsp_ovf_in;

   logic              req_beat;
   logic              store_wr;
   logic              has_room;
   logic [CW-1:0]     last_cnt;
   logic [AW-1:0]     last_idx;
   logic              rsp_load;
   logic [CHAR_W-1:0] first_rdata, second_rdata;
   logic [SW-1:0]     score_rdata;
   logic [SW-1:0]     up, left, diag, cur_score;
   logic [31:0]       final_wide;

   assign req_tready = (state_ff == ST_LOAD);
   assign req_beat   = req_tvalid && req_tready;
   assign has_room   = (count_ff < CW'(MAX_LEN));
   assign store_wr   = req_beat && has_room;
   assign last_cnt   = count_ff - 1'b1;
   assign last_idx   = last_cnt[AW-1:0];
   assign rsp_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   lcs_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_first_ram (
      .clock (clock),
      .we    (store_wr),
      .waddr (count_ff[AW-1:0]),
      .wdata (req_tdata[CHAR_W-1:0]),
      .re    (state_ff == ST_ROW),
      .raddr (row_ff),
      .rdata (first_rdata)
   );

   lcs_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_second_ram (
      .clock (clock),
      .we    (store_wr),
      .waddr (count_ff[AW-1:0]),
      .wdata (req_tdata[2*CHAR_W-1:CHAR_W]),
      .re    (state_ff == ST_SWEEP),
      .raddr (col_ff),
      .rdata (second_rdata)
   );

   // entry j holds the current row's score at column j+1; column 0 is always 0
   lcs_ram #(.WIDTH(SW), .DEPTH(MAX_LEN)) u_score_ram (
      .clock (clock),
      .we    (p_valid_ff),
      .waddr (p_col_ff),
      .wdata (cur_score),
      .re    (state_ff == ST_SWEEP),
      .raddr (col_ff),
      .rdata (score_rdata)
   );

   // cell update; the top row sees zeros above, the first column zeros left
   always_comb begin
      up   = (row_ff == '0) ? '0 : score_rdata;
      left = p_first_col_ff ? '0 : left_ff;
      diag = p_first_col_ff ? '0 : diag_ff;
      if (first_rdata == second_rdata) begin
         cur_score = diag + 1'b1;
      end else begin
         cur_score = (up > left) ? up : left;
      end
   end

   assign final_wide = 32'(left_ff);

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      ovf_in         = ovf_ff;
      row_in         = row_ff;
      col_in         = col_ff;
      p_valid_in     = (state_ff == ST_SWEEP);
      p_col_in       = col_ff;
      p_first_col_in = (col_ff == '0);
      left_in        = left_ff;
      diag_in        = diag_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_len_in     = rsp_len_ff;
      rsp_ovf_in     = rsp_ovf_ff;

      if (p_valid_ff) begin
         left_in = cur_score;
         diag_in = up;
      end

      case (state_ff)
         ST_LOAD: begin
            if (req_beat) begin
               if (has_room) begin
                  count_in = count_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_tlast) begin
                  row_in   = '0;
                  state_in = ST_ROW;
               end
            end
         end
         ST_ROW: begin
            col_in   = '0;
            state_in = ST_SWEEP;
         end
         ST_SWEEP: begin
            col_in = col_ff + 1'b1;
            if (col_ff == last_idx) begin
               state_in = ST_ROW_END;
            end
         end
         ST_ROW_END: begin
            if (row_ff == last_idx) begin
               state_in = ST_DONE;
            end else begin
               row_in   = row_ff + 1'b1;
               state_in = ST_ROW;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               count_in = '0;
               ovf_in   = 1'b0;
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_len_in   = (final_wide > 32'(LEN_SAT)) ? LEN_SAT : final_wide[LEN_W-1:0];
         rsp_ovf_in   = ovf_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         p_valid_ff   <= p_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff         <= row_in;
      col_ff         <= col_in;
      p_col_ff       <= p_col_in;
      p_first_col_ff <= p_first_col_in;
      left_ff        <= left_in;
      diag_ff        <= diag_in;
      rsp_len_ff     <= rsp_len_in;
      rsp_ovf_ff     <= rsp_ovf_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-LEN_W){1'b0}}, rsp_len_ff};
   assign rsp_tuser  = rsp_ovf_ff;

endmodule

// ----- hdl/lcs_length_chk.sv -----
// ----------------------------------------------------------------------------
// lcs_length_chk
// Port-level checks for the subsequence length engine, bound to the top.
// ----------------------------------------------------------------------------
module lcs_length_chk
   import lcs_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic                  req_tlast,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser
);

   // a stalled result beat holds its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   // out of reset the block is empty and ready to load
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not idle after reset");

   // the final pair starts the sweep, so loading stops
   a_last_stops_load: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("input still ready after final pair");

   // padding above the length field stays zero
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_W-1:LEN_W] == '0)
      else $error("result padding bits not zero");

endmodule

bind lcs_length lcs_length_chk u_chk (.*);
